FILE: src/lbw_pkg.sv
// ----------------------------------------------------------------------------
// lbw_pkg: shared definitions for the Lagrange basis weight block
// Widths, register indexes, status codes and the fixed-point constant 1.0.
// ----------------------------------------------------------------------------
package lbw_pkg;

	// Default node store capacity.
	localparam int MAX_NODES_DEF = 8;

	// Field widths.
	localparam int CNT_W  = 4;
	localparam int TOL_W  = 16;
	localparam int VAL_W  = 32;
	localparam int IDX_W  = 3;
	localparam int STAT_W = 2;
	localparam int REG_W  = 16;
	localparam int RIDX_W = 1;

	// Register indexes.
	localparam logic [RIDX_W-1:0] REG_NODE_COUNT = 1'd0;
	localparam logic [RIDX_W-1:0] REG_TOLERANCE  = 1'd1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_BELOW = 2'd1;
	localparam logic [STAT_W-1:0] ST_ABOVE = 2'd2;
	localparam logic [STAT_W-1:0] ST_DEGEN = 2'd3;

	// Request kinds.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	// 1.0 in Q4.28.
	localparam logic [VAL_W-1:0] ONE_Q28 = 32'h1000_0000;

	// Operands of one ratio step: |w| * |num| / |den|.
	typedef struct packed {
		logic [31:0] w_mag;
		logic [32:0] num_mag;
		logic [32:0] den_mag;
	} ratio_req_t;

endpackage

FILE: src/lbw_ratio.sv
// ----------------------------------------------------------------------------
// lbw_ratio: shared multiply and divide unit
// Forms |w| * |num| in two partial products, then divides by |den| with a
// restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lbw_ratio (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  lbw_pkg::ratio_req_t   req,
	output logic                  done,
	output logic [63:0]           quot
);
	import lbw_pkg::*;

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_MLO  = 2'd1;
	localparam logic [1:0] U_MHI  = 2'd2;
	localparam logic [1:0] U_DIV  = 2'd3;

	logic [1:0]  state_q;
	logic [5:0]  cnt_q;
	ratio_req_t  op_q;
	logic [63:0] dq_q;
	logic [32:0] rem_q;
	logic        done_q;

	logic [47:0] pp_lo;
	logic [48:0] pp_hi;
	logic [33:0] trial;
	logic        take;

	// Partial products and one divider step.
	assign pp_lo = op_q.w_mag * op_q.num_mag[15:0];
	assign pp_hi = op_q.w_mag * op_q.num_mag[32:16];
	assign trial = {rem_q, dq_q[63]};
	assign take  = trial >= {1'b0, op_q.den_mag};

	// Sequencer of the unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (start) state_q <= U_MLO;
				end
				U_MLO: state_q <= U_MHI;
				U_MHI: begin
					state_q <= U_DIV;
					cnt_q   <= '0;
				end
				U_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= U_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	// Operand, product and quotient registers.
	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (start) op_q <= req;
			end
			U_MLO: dq_q <= {16'd0, pp_lo};
			U_MHI: begin
				dq_q  <= dq_q + 64'({pp_hi, 16'd0});
				rem_q <= '0;
			end
			U_DIV: begin
				// The remainder stays below the divisor, so 33 bits hold it.
				rem_q <= take ? 33'(trial - {1'b0, op_q.den_mag}) : trial[32:0];
				dq_q  <= {dq_q[62:0], take};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = dq_q;

endmodule

FILE: src/lagrange_basis_weights.sv
// ----------------------------------------------------------------------------
// lagrange_basis_weights: Lagrange interpolation basis weights
// Stores node positions and returns l_k(x0) per node as saturated Q4.28.
// ----------------------------------------------------------------------------
// A load word is written into the store when it is accepted, and the block
// stays idle for the next word. An evaluation with one node, or with a point
// out of range, gives its single result word. In a full evaluation every
// factor goes through the one shared multiply and divide unit, which
// captures the operands, forms two partial products and runs 64 divider
// steps once the factor is set up. The slave side is not ready while an
// evaluation runs; the output register lets the last result wait while the
// next word is accepted.
module lagrange_basis_weights #(
	parameter int MAX_NODES = lbw_pkg::MAX_NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Slave side. tdata: node_index[2:0], node_value[34:3], eval_point[66:35].
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [71:0]                 s_tdata,
	// tuser: req_type[0].
	input  logic                        s_tuser,
	// Master side. tdata: weight_index[2:0], weight[34:3].
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [39:0]                 m_tdata,
	// tuser: status[1:0].
	output logic [lbw_pkg::STAT_W-1:0]  m_tuser,
	output logic                        m_tlast,
	// Configuration write port.
	input  logic                        cfg_we,
	input  logic [lbw_pkg::RIDX_W-1:0]  cfg_index,
	input  logic [lbw_pkg::REG_W-1:0]   cfg_data
);
	import lbw_pkg::*;

	localparam int NODE_CAP = (MAX_NODES < 8) ? MAX_NODES : 8;
	localparam int SW       = (NODE_CAP > 1) ? $clog2(NODE_CAP) : 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LO    = 4'd1;
	localparam logic [3:0] S_HI    = 4'd2;
	localparam logic [3:0] S_KST   = 4'd3;
	localparam logic [3:0] S_DEG   = 4'd4;
	localparam logic [3:0] S_FAC   = 4'd5;
	localparam logic [3:0] S_WAIT  = 4'd6;
	localparam logic [3:0] S_EMIT  = 4'd7;

	logic [3:0]             state_q;
	logic [CNT_W-1:0]       node_count_q;
	logic [TOL_W-1:0]       tol_q;
	logic signed [VAL_W-1:0] store_q [NODE_CAP];
	logic signed [VAL_W-1:0] x0_q, xk_q, w_q;
	logic [CNT_W-1:0]       n_q, k_q, i_q;
	logic                   deg_q, neg_q, start_q;
	logic [IDX_W-1:0]       r_idx_q;
	logic [VAL_W-1:0]       r_w_q;
	logic [STAT_W-1:0]      r_st_q;
	logic                   r_last_q;
	logic                   mv_q;
	logic [IDX_W-1:0]       m_idx_q;
	logic [VAL_W-1:0]       m_w_q;
	logic [STAT_W-1:0]      m_st_q;
	logic                   m_last_q;
	ratio_req_t             req_q;

	logic                   s_acc;
	logic [IDX_W-1:0]       in_idx;
	logic signed [VAL_W-1:0] in_val, in_pt;
	logic [CNT_W-1:0]       n_eff, n_last, rd_sel;
	logic signed [VAL_W-1:0] rd;
	logic signed [32:0]     d_x0, d_xk, d_k;
	logic signed [33:0]     tol_s;
	logic [32:0]            d_k_mag;
	logic                   u_done;
	logic [63:0]            u_quot;
	logic [VAL_W-1:0]       w_new;
	logic                   emit_go;

	assign in_idx   = s_tdata[2:0];
	assign in_val   = s_tdata[34:3];
	assign in_pt    = s_tdata[66:35];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// Node count clamped to the range from one to the store capacity.
	always_comb begin
		if (node_count_q == '0) n_eff = 4'd1;
		else if (node_count_q > 4'(NODE_CAP)) n_eff = 4'(NODE_CAP);
		else n_eff = node_count_q;
	end
	assign n_last = n_q - 4'd1;

	// One store read a cycle, at the slot the sequencer needs.
	always_comb begin
		case (state_q)
			S_LO:    rd_sel = '0;
			S_HI:    rd_sel = n_last;
			S_KST:   rd_sel = k_q;
			default: rd_sel = i_q;
		endcase
	end
	assign rd = store_q[rd_sel[SW-1:0]];

	// Differences against the point and against node k.
	assign d_x0    = 33'(x0_q) - 33'(rd);
	assign d_xk    = 33'(xk_q) - 33'(rd);
	assign d_k     = d_x0;
	assign d_k_mag = d_k[32] ? 33'(-d_k) : 33'(d_k);
	assign tol_s   = 34'(tol_q);

	// Sign, truncation and saturation of one ratio step.
	always_comb begin
		if (u_quot == '0) w_new = '0;
		else if (neg_q) w_new = (u_quot >= 64'h8000_0000) ? 32'h8000_0000 : -u_quot[31:0];
		else w_new = (u_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : u_quot[31:0];
	end

	assign emit_go = !mv_q || m_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 4'd4;
			tol_q        <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODE_COUNT: node_count_q <= cfg_data[CNT_W-1:0];
				REG_TOLERANCE:  tol_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Node store written by load words.
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == REQ_LOAD && 4'(in_idx) < 4'(NODE_CAP))
			store_q[in_idx[SW-1:0]] <= in_val;
	end

	// Evaluation sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_acc && s_tuser == REQ_EVAL)
						state_q <= (n_eff == 4'd1) ? S_EMIT : S_LO;
				end
				S_LO:   state_q <= (34'(d_x0) < -tol_s) ? S_EMIT : S_HI;
				S_HI:   state_q <= (34'(d_x0) > tol_s) ? S_EMIT : S_KST;
				S_KST:  state_q <= (34'(d_k_mag) < tol_s) ? S_EMIT : S_DEG;
				S_DEG: begin
					if (i_q == n_last)
						state_q <= (deg_q || (i_q != k_q && rd == xk_q)) ? S_EMIT : S_FAC;
				end
				S_FAC: begin
					if (i_q == k_q) begin
						if (i_q == n_last) state_q <= S_EMIT;
					end else begin
						state_q <= S_WAIT;
						start_q <= 1'b1;
					end
				end
				S_WAIT: begin
					if (u_done) state_q <= (i_q == n_last) ? S_EMIT : S_FAC;
				end
				S_EMIT: begin
					if (emit_go) state_q <= r_last_q ? S_IDLE : S_KST;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and the pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x0_q     <= in_pt;
				n_q      <= n_eff;
				k_q      <= '0;
				r_idx_q  <= '0;
				r_w_q    <= ONE_Q28;
				r_st_q   <= ST_OK;
				r_last_q <= 1'b1;
			end
			S_LO: begin
				r_w_q  <= '0;
				r_st_q <= ST_BELOW;
			end
			S_HI: begin
				r_st_q <= ST_ABOVE;
			end
			S_KST: begin
				xk_q     <= rd;
				deg_q    <= 1'b0;
				i_q      <= '0;
				r_idx_q  <= k_q[IDX_W-1:0];
				r_w_q    <= ONE_Q28;
				r_st_q   <= ST_OK;
				r_last_q <= (k_q == n_last);
			end
			S_DEG: begin
				if (i_q != k_q && rd == xk_q) deg_q <= 1'b1;
				if (i_q == n_last) begin
					i_q    <= '0;
					w_q    <= ONE_Q28;
					r_w_q  <= '0;
					r_st_q <= ST_DEGEN;
				end else begin
					i_q <= i_q + 4'd1;
				end
			end
			S_FAC: begin
				r_w_q  <= w_q;
				r_st_q <= ST_OK;
				if (i_q == k_q) begin
					i_q <= i_q + 4'd1;
				end else begin
					neg_q         <= w_q[31] ^ d_x0[32] ^ d_xk[32];
					req_q.w_mag   <= w_q[31] ? -w_q : w_q;
					req_q.num_mag <= d_x0[32] ? 33'(-d_x0) : 33'(d_x0);
					req_q.den_mag <= d_xk[32] ? 33'(-d_xk) : 33'(d_xk);
				end
			end
			S_WAIT: begin
				if (u_done) begin
					w_q   <= w_new;
					r_w_q <= w_new;
					i_q   <= i_q + 4'd1;
				end
			end
			S_EMIT: begin
				if (emit_go) k_q <= k_q + 4'd1;
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (state_q == S_EMIT && emit_go) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && emit_go) begin
			m_idx_q  <= r_idx_q;
			m_w_q    <= r_w_q;
			m_st_q   <= r_st_q;
			m_last_q <= r_last_q;
		end
	end

	lbw_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.req    (req_q),
		.done   (u_done),
		.quot   (u_quot)
	);

	assign m_tvalid = mv_q;
	assign m_tdata  = {5'd0, m_w_q, m_idx_q};
	assign m_tuser  = m_st_q;
	assign m_tlast  = m_last_q;

endmodule

FILE: src/lbw_checker.sv
// ----------------------------------------------------------------------------
// lbw_checker: port-level checks for the Lagrange basis weight block
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lbw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import lbw_pkg::*;

	// A result word that is not taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// A range error is the only word of its evaluation and carries weight zero.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_BELOW || m_tuser == ST_ABOVE)
		|-> m_tlast && m_tdata[34:3] == '0)
		else $error("range error word malformed");

	// A degenerate node gives weight zero.
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_DEGEN |-> m_tdata[34:3] == '0)
		else $error("degenerate word has non-zero weight");

	// An accepted evaluation word makes the block busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == REQ_EVAL |=> !s_tready)
		else $error("ready during evaluation");

endmodule

bind lagrange_basis_weights lbw_checker u_lbw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
